// ===== hdl/bat_pkg.sv =====
// Package for the breakpoint address table: command and status codes,
// field widths and the beat types passed between the table and its top level.
// No dependencies.
package bat_pkg;

   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 64;
   localparam int STATUS_W  = 2;
   localparam int USED_W    = 5;
   localparam int USED_MAX  = 31;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [USED_W-1:0]   entries_used;
   } rsp_type;

endpackage

// ===== hdl/bat_slots.sv =====
// Slot array of the breakpoint address table: valid bits, stored addresses,
// parallel compare, free-slot pick and occupancy count. Depends on bat_pkg.
module bat_slots #(
   parameter int SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  bat_pkg::req_type req,
   output bat_pkg::rsp_type rsp
);
   import bat_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CW    = (CNT_W > USED_W) ? CNT_W : USED_W;

   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [ADDR_W-1:0]   addr_ff [SLOTS];
   logic [SLOTS-1:0]    match;
   logic [SLOTS-1:0]    free;
   logic [SLOTS-1:0]    free_1h;
   logic [CW-1:0]       cnt;
   logic                hit_c;
   logic [STATUS_W-1:0] status_c;
   logic [USED_W-1:0]   used_c;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = valid_ff[i] && (addr_ff[i] == req.address);
      end
   end

   // lowest free slot as a one-hot vector
   assign free    = ~valid_ff;
   assign free_1h = free & (~free + SLOTS'(1));

   always_comb begin
      valid_in = valid_ff;
      hit_c    = 1'b0;
      status_c = ST_OK;
      unique case (req.cmd)
         CMD_ADD: begin
            if (|free) valid_in = valid_ff | free_1h;
            else status_c = ST_FULL;
         end
         CMD_REMOVE: begin
            valid_in = valid_ff & ~match;
            if (!(|match)) status_c = ST_NOMATCH;
         end
         CMD_CHECK: begin
            hit_c = |match;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_comb begin
      cnt = '0;
      for (int i = 0; i < SLOTS; i++) begin
         cnt = cnt + CW'(valid_in[i]);
      end
      used_c = (cnt > CW'(USED_MAX)) ? USED_W'(USED_MAX) : cnt[USED_W-1:0];
   end

   assign rsp = {hit_c, status_c, used_c};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (fire) begin
         valid_ff <= valid_in;
      end
   end

   // address store needs no reset; an entry is only compared while valid
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (fire && (req.cmd == CMD_ADD) && free_1h[i]) begin
            addr_ff[i] <= req.address;
         end
      end
   end

   // an add into a table with room always claims exactly one slot
   a_add_one_slot: assert property (@(posedge clock) disable iff (reset)
      fire && (req.cmd == CMD_ADD) && (|free) |=> $countones(valid_ff) ==
      $countones($past(valid_ff)) + 1)
      else $error("add did not claim exactly one slot");

   // a remove leaves no valid slot holding the removed address
   a_remove_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (req.cmd == CMD_REMOVE) |-> (valid_in & match) == '0)
      else $error("remove left a matching slot valid");

   a_free_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(free_1h))
      else $error("free slot pick is not one-hot");

endmodule

// ===== hdl/breakpoint_address_table.sv =====
// Top level of the breakpoint address table: input register, slot array and
// result register with valid/ready handshakes. Depends on bat_pkg, bat_slots.
//
// A table of SLOTS breakpoint addresses with a valid bit each. Every command
// beat (add, remove, check) returns exactly one result beat. Add writes the
// lowest free slot (duplicates allowed) and reports full when no slot is
// free; remove clears every valid slot holding the address and reports no
// match when none does; check compares against all valid slots in parallel.
// entries_used gives the occupancy after the command, saturating at 31.
// The block takes one command per clock unless results are stalled: the
// compare, free-slot pick and table update are computed between the input
// register and the result register, so a command sees every earlier
// command's update. A command beat waits in the input register while the
// table logic works on it; the result register presents the answer once
// the command fires, which waits while the result register holds an untaken
// beat. The result register frees as its beat is taken, so the input
// side keeps flowing under back-pressure until both registers hold a beat.
module breakpoint_address_table #(
   parameter int SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bat_pkg::CMD_W-1:0]           req_cmd,
   input  logic [bat_pkg::ADDR_W-1:0]          req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [bat_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bat_pkg::USED_W-1:0]          rsp_entries_used
);
   import bat_pkg::*;

   // input register
   logic    in_valid_ff;
   req_type in_ff;
   // result register
   logic    out_valid_ff;
   rsp_type out_ff;

   rsp_type slot_rsp;
   logic    fire;

   // process the held command when the result register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // hold the command beat until it is processed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff.cmd     <= req_cmd;
         in_ff.address <= req_address;
      end
   end

   bat_slots #(
      .SLOTS (SLOTS)
   ) u_slots (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_ff),
      .rsp   (slot_rsp)
   );

   // advance the result register on fire, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= slot_rsp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hit          = out_ff.hit;
   assign rsp_status       = out_ff.status;
   assign rsp_entries_used = out_ff.entries_used;

   // a hit comes only from a check, which always reports ok
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.hit |-> out_ff.status == ST_OK)
      else $error("hit reported with a non-ok status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.status == ST_OK || out_ff.status == ST_FULL ||
                        out_ff.status == ST_NOMATCH))
      else $error("result carries an unknown status code");

   // a stalled command stays in the input register unchanged
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_ff))
      else $error("stalled command was lost or changed");

   a_ready_means_room: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled without a full pipeline");

endmodule
